@@ src/dlr_pkg.sv @@
// Shared types and constants of the DDA line rasteriser.
package dlr_pkg;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned PITCH_W     = 13;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd1024;

  localparam logic REG_ROW_PITCH = 1'b0;

  typedef enum logic {
    OP_BEGIN   = 1'b0,
    OP_ADVANCE = 1'b1
  } opcode_e;

  typedef struct packed {
    logic load_line;
    logic div_step;
    logic div_done;
    logic advance;
  } dlr_cmd_t;

  typedef struct packed {
    logic step_zero;
  } dlr_status_t;

endpackage

@@ src/dlr_div.sv @@
// Restoring divider, one quotient bit per step, for one axis increment.
module dlr_div #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic                  step_i,
  input  logic [COORD_BITS-1:0] mag_i,
  input  logic [COORD_BITS-1:0] divisor_i,
  output logic [FRAC_BITS:0]    quo_o
);

  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS-1:0] div_q;
  logic [FRAC_BITS:0]    quo_q, quo_d;
  logic [COORD_BITS:0]   shifted;
  logic                  ge;

  always_comb begin
    shifted = {rem_q, 1'b0};
    ge      = 1'b0;
    rem_d   = rem_q;
    quo_d   = quo_q;
    if (load_i) begin
      // magnitude never exceeds the divisor, so the integer bit is 0 or 1
      ge    = mag_i >= divisor_i;
      rem_d = ge ? (mag_i - divisor_i) : mag_i;
      quo_d = {{FRAC_BITS{1'b0}}, ge};
    end else if (step_i) begin
      ge    = shifted >= {1'b0, div_q};
      rem_d = ge ? COORD_BITS'(shifted - {1'b0, div_q}) : shifted[COORD_BITS-1:0];
      quo_d = {quo_q[FRAC_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (load_i) begin
      div_q <= divisor_i;
    end
  end

  assign quo_o = quo_q;

endmodule

@@ src/dlr_datapath.sv @@
// Datapath: line set-up, position accumulators, address generation, result register.
module dlr_datapath #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dlr_pkg::dlr_cmd_t             cmd_i,
  output dlr_pkg::dlr_status_t          status_o,
  input  logic [COORD_BITS-1:0]         start_x_i,
  input  logic [COORD_BITS-1:0]         start_y_i,
  input  logic [COORD_BITS-1:0]         end_x_i,
  input  logic [COORD_BITS-1:0]         end_y_i,
  input  logic [dlr_pkg::COLOR_W-1:0]   pen_color_i,
  input  logic [dlr_pkg::PITCH_W-1:0]   row_pitch_i,
  output logic [dlr_pkg::ADDR_W-1:0]    pixel_address_o,
  output logic [dlr_pkg::COLOR_W-1:0]   pixel_color_o,
  output logic                          pixel_valid_o,
  output logic                          last_o
);
  import dlr_pkg::*;

  localparam int unsigned POS_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned INC_W  = FRAC_BITS + 2;
  localparam int unsigned LEFT_W = COORD_BITS + 1;
  localparam int unsigned SUM_W  = (COORD_BITS + 15 > ADDR_W) ? COORD_BITS + 15 : ADDR_W;

  logic [POS_W-1:0]      cur_x_q, cur_y_q;
  logic [INC_W-1:0]      inc_x_q, inc_y_q;
  logic [LEFT_W-1:0]     pixels_left_q;
  logic [COLOR_W-1:0]    line_color_q;
  logic                  neg_x_q, neg_y_q;

  logic [ADDR_W-1:0]     addr_q;
  logic [COLOR_W-1:0]    color_q;
  logic                  valid_q, last_q;

  logic [COORD_BITS-1:0] adx, ady, step;
  logic [FRAC_BITS:0]    quo_x, quo_y;
  logic [COORD_BITS:0]   col, row;
  logic [SUM_W-1:0]      addr_sum;
  logic                  have_pixel;

  assign adx  = (end_x_i >= start_x_i) ? (end_x_i - start_x_i) : (start_x_i - end_x_i);
  assign ady  = (end_y_i >= start_y_i) ? (end_y_i - start_y_i) : (start_y_i - end_y_i);
  assign step = (adx > ady) ? adx : ady;
  assign status_o.step_zero = (step == '0);

  dlr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk_i     (clk_i),
    .load_i    (cmd_i.load_line),
    .step_i    (cmd_i.div_step),
    .mag_i     (adx),
    .divisor_i (step),
    .quo_o     (quo_x)
  );

  dlr_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk_i     (clk_i),
    .load_i    (cmd_i.load_line),
    .step_i    (cmd_i.div_step),
    .mag_i     (ady),
    .divisor_i (step),
    .quo_o     (quo_y)
  );

  assign col        = cur_x_q[POS_W-1:FRAC_BITS];
  assign row        = cur_y_q[POS_W-1:FRAC_BITS];
  assign addr_sum   = SUM_W'(row) * SUM_W'(row_pitch_i) + SUM_W'(col);
  assign have_pixel = (pixels_left_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_left_q <= '0;
    end else if (cmd_i.load_line) begin
      pixels_left_q <= LEFT_W'(step);
    end else if (cmd_i.advance && have_pixel) begin
      pixels_left_q <= pixels_left_q - LEFT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_line) begin
      cur_x_q      <= {1'b0, start_x_i, {FRAC_BITS{1'b0}}};
      cur_y_q      <= {1'b0, start_y_i, {FRAC_BITS{1'b0}}};
      line_color_q <= pen_color_i;
      neg_x_q      <= end_x_i < start_x_i;
      neg_y_q      <= end_y_i < start_y_i;
      inc_x_q      <= '0;
      inc_y_q      <= '0;
    end else if (cmd_i.div_done) begin
      inc_x_q <= neg_x_q ? (INC_W'(0) - {1'b0, quo_x}) : {1'b0, quo_x};
      inc_y_q <= neg_y_q ? (INC_W'(0) - {1'b0, quo_y}) : {1'b0, quo_y};
    end else if (cmd_i.advance && have_pixel) begin
      cur_x_q <= cur_x_q + {{(POS_W-INC_W){inc_x_q[INC_W-1]}}, inc_x_q};
      cur_y_q <= cur_y_q + {{(POS_W-INC_W){inc_y_q[INC_W-1]}}, inc_y_q};
    end
  end

  // result register, loaded on every advance request
  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      addr_q  <= have_pixel ? addr_sum[ADDR_W-1:0] : '0;
      color_q <= have_pixel ? line_color_q : '0;
      valid_q <= have_pixel;
      last_q  <= (pixels_left_q == LEFT_W'(1));
    end
  end

  assign pixel_address_o = addr_q;
  assign pixel_color_o   = color_q;
  assign pixel_valid_o   = valid_q;
  assign last_o          = last_q;

endmodule

@@ src/dlr_ctrl.sv @@
// Controller: request handshakes, divide sequencing and result-register occupancy.
module dlr_ctrl #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  dlr_pkg::dlr_status_t status_i,
  output dlr_pkg::dlr_cmd_t    cmd_o
);
  import dlr_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAC_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o.load_line = accept && (opcode_i == OP_BEGIN);
    cmd_o.advance   = accept && (opcode_i == OP_ADVANCE);
    cmd_o.div_step  = (state_q == ST_DIVIDE);
    cmd_o.div_done  = (state_q == ST_FINISH);

    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      ST_IDLE: begin
        count_d = '0;
        if (cmd_o.load_line && !status_i.step_zero) begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (count_q == CNT_LAST) begin
          state_d = ST_FINISH;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    priority if (cmd_o.advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_begin_divides: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_line && !status_i.step_zero) |=> (state_q == ST_DIVIDE))
    else $error("line set-up did not start the divide");

  a_finish_after_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |-> ($past(state_q) == ST_DIVIDE && $past(count_q) == CNT_LAST))
    else $error("finish step reached without a full divide");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> (count_q <= CNT_LAST))
    else $error("divide counter overran");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("pending result dropped");

endmodule

@@ src/dda_line_rasterizer.sv @@
// Top level of the DDA line rasteriser: stream ports, APB register, controller and datapath.
//
//  channel   | direction | handshake                  | payload
//  s_axis    | in        | s_axis_tvalid/tready       | tuser opcode, tdata line set-up
//  m_axis    | out       | m_axis_tvalid/tready       | tuser pixel_valid, tlast, tdata pixel
//  apb       | in        | psel/penable, pready high  | row_pitch at byte address 0
//
//  One advance request may be accepted every cycle while the output register is free or draining.
//  A begin request with a nonzero length blocks input while the one-bit-per-cycle restoring
//  dividers for the two increments run and the increments are registered.
//  A zero-length begin request starts no divide.
//  Results sit in one output register; input is accepted while it drains.
//  Reset clears control state and pixels left; row_pitch resets to 1024.
module dda_line_rasterizer #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // start_x, start_y, end_x, end_y, pen_color, zero fill
  input  logic [((4*COORD_BITS+24+7)/8)*8-1:0] s_axis_tdata_i,
  // opcode
  input  logic                               s_axis_tuser_i,
  // master stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // pixel_address, pixel_color
  output logic [47:0]                        m_axis_tdata_o,
  // pixel_valid
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o,
  // APB
  input  logic                               psel_i,
  input  logic                               penable_i,
  input  logic                               pwrite_i,
  input  logic [dlr_pkg::APB_ADDR_W-1:0]     paddr_i,
  input  logic [dlr_pkg::APB_DATA_W-1:0]     pwdata_i,
  output logic [dlr_pkg::APB_DATA_W-1:0]     prdata_o,
  output logic                               pready_o
);
  import dlr_pkg::*;

  logic [PITCH_W-1:0] row_pitch_q;
  logic               reg_hit;
  dlr_cmd_t           cmd;
  dlr_status_t        status;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;

  assign pready_o = 1'b1;
  assign reg_hit  = (paddr_i[APB_ADDR_W-1] == REG_ROW_PITCH);
  assign prdata_o = reg_hit ? APB_DATA_W'(row_pitch_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_pitch_q <= PITCH_RESET;
    end else if (psel_i && penable_i && pwrite_i && pready_o && reg_hit) begin
      row_pitch_q <= pwdata_i[PITCH_W-1:0];
    end
  end

  dlr_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .opcode_i    (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dlr_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .start_x_i       (s_axis_tdata_i[COORD_BITS-1:0]),
    .start_y_i       (s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i         (s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i         (s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS]),
    .pen_color_i     (s_axis_tdata_i[4*COORD_BITS+COLOR_W-1:4*COORD_BITS]),
    .row_pitch_i     (row_pitch_q),
    .pixel_address_o (pixel_address),
    .pixel_color_o   (pixel_color),
    .pixel_valid_o   (m_axis_tuser_o),
    .last_o          (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {pixel_color, pixel_address};

endmodule

@@ tb/dlr_checker.sv @@
// Stream monitor for the DDA line rasteriser: tracks the line state, predicts each pixel and compares it.
module dlr_checker #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned S_DATA_W   = 72
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid_i,
  input  logic                           s_tready_i,
  // start_x, start_y, end_x, end_y, pen_color, zero fill
  input  logic [S_DATA_W-1:0]            s_tdata_i,
  // opcode
  input  logic                           s_tuser_i,
  input  logic                           m_tvalid_i,
  input  logic                           m_tready_i,
  // pixel_address, pixel_color
  input  logic [47:0]                    m_tdata_i,
  // pixel_valid
  input  logic                           m_tuser_i,
  input  logic                           m_tlast_i,
  input  logic                           psel_i,
  input  logic                           penable_i,
  input  logic                           pwrite_i,
  input  logic                           pready_i,
  input  logic [dlr_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [dlr_pkg::APB_DATA_W-1:0] pwdata_i,
  output int                             fail_cnt_o,
  output int                             pending_o,
  output int                             line_cnt_o,
  output int                             pixel_cnt_o,
  output int                             end_cnt_o,
  output int                             empty_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dlr_pkg::*;

  localparam int unsigned POS_W  = COORD_BITS + FRAC_BITS + 1;
  localparam int unsigned INC_W  = FRAC_BITS + 2;
  localparam int unsigned LEFT_W = COORD_BITS + 1;
  localparam logic [APB_ADDR_W-1:0] PITCH_ADDR = {REG_ROW_PITCH, 2'b00};

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               valid;
    logic               last;
  } pixel_t;

  logic [PITCH_W-1:0] pitch;
  logic [POS_W-1:0]   pos_x, pos_y;
  logic [INC_W-1:0]   step_x, step_y;
  logic [LEFT_W-1:0]  left;
  logic [COLOR_W-1:0] colour;
  pixel_t             pixel_q[$];

  // per-axis increment: |d| scaled by 2^FRAC_BITS over the major length, sign applied after
  function automatic logic [INC_W-1:0] axis_step(input logic [COORD_BITS-1:0] p0,
                                                 input logic [COORD_BITS-1:0] p1,
                                                 input logic [LEFT_W-1:0] len);
    logic [COORD_BITS+FRAC_BITS-1:0] q;
    q = (p1 < p0) ? p0 - p1 : p1 - p0;
    q = q << FRAC_BITS;
    q = q / len;
    if (p1 < p0) q = ~q + 1'b1;
    return q[INC_W-1:0];
  endfunction

  task automatic load_line(input logic [S_DATA_W-1:0] d);
    logic [COORD_BITS-1:0] sx, sy, ex, ey;
    logic [LEFT_W-1:0]     adx, ady;
    sx = d[0 +: COORD_BITS];
    sy = d[COORD_BITS +: COORD_BITS];
    ex = d[2*COORD_BITS +: COORD_BITS];
    ey = d[3*COORD_BITS +: COORD_BITS];
    adx = (ex >= sx) ? ex - sx : sx - ex;
    ady = (ey >= sy) ? ey - sy : sy - ey;
    left = (adx > ady) ? adx : ady;
    pos_x = {1'b0, sx, {FRAC_BITS{1'b0}}};
    pos_y = {1'b0, sy, {FRAC_BITS{1'b0}}};
    colour = d[4*COORD_BITS +: COLOR_W];
    if (left == '0) begin
      step_x = '0;
      step_y = '0;
    end else begin
      step_x = axis_step(sx, ex, left);
      step_y = axis_step(sy, ey, left);
    end
    line_cnt_o++;
  endtask

  function automatic pixel_t draw_pixel();
    pixel_t     px;
    logic [31:0] wide;
    px = '0;
    if (left == '0) begin
      empty_cnt_o++;
      return px;
    end
    wide = 32'(pos_y[POS_W-1:FRAC_BITS]) * 32'(pitch) + 32'(pos_x[POS_W-1:FRAC_BITS]);
    px.addr  = wide[ADDR_W-1:0];
    px.color = colour;
    px.valid = 1'b1;
    px.last  = (left == 1);
    pos_x = pos_x + {{(POS_W-INC_W){step_x[INC_W-1]}}, step_x};
    pos_y = pos_y + {{(POS_W-INC_W){step_y[INC_W-1]}}, step_y};
    left = left - 1'b1;
    pixel_cnt_o++;
    if (px.last) end_cnt_o++;
    return px;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    pixel_t want, got;
    if (!rst_ni) begin
      pitch = PITCH_RESET;
      pos_x = '0;
      pos_y = '0;
      step_x = '0;
      step_y = '0;
      left = '0;
      colour = '0;
      pixel_q.delete();
      fail_cnt_o = 0;
      line_cnt_o = 0;
      pixel_cnt_o = 0;
      end_cnt_o = 0;
      empty_cnt_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == PITCH_ADDR)
        pitch = pwdata_i[PITCH_W-1:0];
      if (m_tvalid_i && m_tready_i) begin
        got.addr  = m_tdata_i[ADDR_W-1:0];
        got.color = m_tdata_i[ADDR_W +: COLOR_W];
        got.valid = m_tuser_i;
        got.last  = m_tlast_i;
        if (pixel_q.size() == 0) begin
          if (fail_cnt_o < 10)
            $display("%0t unexpected pixel: addr %06h colour %06h valid %0b last %0b",
                     $realtime, got.addr, got.color, got.valid, got.last);
          fail_cnt_o++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            if (fail_cnt_o < 10) begin
              $display("%0t pixel mismatch: expected addr %06h colour %06h valid %0b last %0b",
                       $realtime, want.addr, want.color, want.valid, want.last);
              $display("%0t                 got addr %06h colour %06h valid %0b last %0b",
                       $realtime, got.addr, got.color, got.valid, got.last);
            end
            fail_cnt_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == OP_ADVANCE) pixel_q.push_back(draw_pixel());
        else load_line(s_tdata_i);
      end
    end
    pending_o = pixel_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the DDA line rasteriser: clock, reset, line requests, pitch writes and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dlr_pkg::*;

  localparam int unsigned COORD_BITS   = 12;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned S_DATA_W     = ((4*COORD_BITS+24+7)/8)*8;
  localparam int unsigned DRAIN_CYCLES = 2*(FRAC_BITS+2) + 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned COORD_MAX    = (1 << COORD_BITS) - 1;
  localparam logic [APB_ADDR_W-1:0] PITCH_ADDR = {REG_ROW_PITCH, 2'b00};

  typedef enum logic [2:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_EVERY4TH, RX_SPARSE} rx_pattern_e;

  logic                  clk_i, rst_ni;
  logic                  s_valid, s_ready, s_user;
  logic [S_DATA_W-1:0]   s_data;
  logic                  m_valid, m_ready, m_user, m_last;
  logic [47:0]           m_data;
  logic                  psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;

  int fails, pending, lines, pixels, line_ends, empties;
  int items_sent, burst_left, holds_wanted, holds_done;

  dda_line_rasterizer #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  dlr_checker #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .S_DATA_W(S_DATA_W)) u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_valid), .s_tready_i(s_ready), .s_tdata_i(s_data), .s_tuser_i(s_user),
    .m_tvalid_i(m_valid), .m_tready_i(m_ready), .m_tdata_i(m_data),
    .m_tuser_i(m_user), .m_tlast_i(m_last),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .fail_cnt_o(fails), .pending_o(pending), .line_cnt_o(lines),
    .pixel_cnt_o(pixels), .end_cnt_o(line_ends), .empty_cnt_o(empties)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin : receiver
    rx_pattern_e pattern;
    int          run_left, cyc;
    m_ready = 1'b0;
    run_left = 0;
    cyc = 0;
    pattern = RX_OPEN;
    forever begin
      @(posedge clk_i);
      if (holds_done < holds_wanted) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      if (run_left == 0) begin
        pattern = rx_pattern_e'($urandom_range(0, 4));
        run_left = $urandom_range(8, 120);
      end
      run_left--;
      cyc++;
      case (pattern)
        RX_OPEN:     m_ready <= 1'b1;
        RX_COIN:     m_ready <= $urandom_range(0, 1);
        RX_MOSTLY:   m_ready <= ($urandom_range(0, 4) != 0);
        RX_EVERY4TH: m_ready <= (cyc % 4 != 0);
        default:     m_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic push_request(input opcode_e op, input logic [S_DATA_W-1:0] payload);
    logic took;
    int   gap;
    s_user  <= op;
    s_data  <= payload;
    s_valid <= 1'b1;
    do begin
      @(negedge clk_i);
      took = s_ready;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic begin_line(input int sx, input int sy, input int ex, input int ey,
                            input logic [COLOR_W-1:0] colour);
    logic [COORD_BITS-1:0] c0, c1, c2, c3;
    c0 = sx[COORD_BITS-1:0];
    c1 = sy[COORD_BITS-1:0];
    c2 = ex[COORD_BITS-1:0];
    c3 = ey[COORD_BITS-1:0];
    push_request(OP_BEGIN, {colour, c3, c2, c1, c0});
  endtask

  // advance requests carry junk in the unused payload
  task automatic advance(input int n);
    repeat (n) push_request(OP_ADVANCE, S_DATA_W'({$urandom(), $urandom(), $urandom()}));
  endtask

  task automatic wait_idle();
    s_valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_pitch(input int unsigned value);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PITCH_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly short, complete lines; some long ones cut short, some stray advances
  task automatic random_segment();
    int r, span, n, dx, dy, len;
    int p[4];
    logic [COLOR_W-1:0] colour;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      advance($urandom_range(1, 3));
      return;
    end
    for (int i = 0; i < 2; i++)
      p[i] = ($urandom_range(0, 9) == 0) ? COORD_MAX * $urandom_range(0, 1)
                                         : $urandom_range(0, COORD_MAX);
    r = $urandom_range(0, 99);
    span = (r < 85) ? 12 : (r < 97) ? 60 : COORD_MAX;
    for (int i = 0; i < 2; i++) begin
      p[i+2] = p[i] + int'($urandom_range(0, 2*span)) - span;
      if (p[i+2] < 0) p[i+2] = 0;
      if (p[i+2] > COORD_MAX) p[i+2] = COORD_MAX;
    end
    if ($urandom_range(0, 19) == 0) begin
      p[2] = p[0];
      p[3] = p[1];
    end
    case ($urandom_range(0, 9))
      0:       colour = '0;
      1:       colour = '1;
      default: colour = COLOR_W'($urandom());
    endcase
    begin_line(p[0], p[1], p[2], p[3], colour);
    dx = (p[2] > p[0]) ? p[2] - p[0] : p[0] - p[2];
    dy = (p[3] > p[1]) ? p[3] - p[1] : p[1] - p[3];
    len = (dx > dy) ? dx : dy;
    if (len <= 60 && $urandom_range(0, 4) != 0) n = len + $urandom_range(0, 2);
    else n = $urandom_range(0, (len < 40) ? len : 40);
    advance(n);
  endtask

  initial begin : stimulus
    int unsigned pitches[7];
    s_valid = 1'b0;
    s_user = 1'b0;
    s_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    items_sent = 0;
    burst_left = 0;
    holds_wanted = 0;
    holds_done = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset pitch
    advance(1);
    begin_line(COORD_MAX, COORD_MAX, 0, 0, 24'hffffff);
    advance(3);
    begin_line(0, 0, COORD_MAX, COORD_MAX, 24'h000000);
    advance(2);
    begin_line(7, 9, 7, 9, 24'h123456);
    advance(1);
    begin_line(10, 10, 13, 11, 24'h00ff00);
    advance(4);
    begin_line(5, 0, 3, 4, 24'hff0000);
    advance(5);
    begin_line(100, 200, 99, 200, 24'h0000ff);
    advance(2);

    pitches = '{1, 4096, 0, 8191, $urandom_range(1, 4096), $urandom_range(0, 8191), 1024};
    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      write_pitch(pitches[ph]);
      if (ph == 1 || ph == 4) holds_wanted++;
      while (items_sent < 24 + (ph + 1) * 220) random_segment();
    end
    wait_idle();

    $display("tb: %0d requests, %0d lines set up, %0d pixels drawn (%0d line ends)",
             items_sent, lines, pixels, line_ends);
    $display("tb: %0d advances past line end, 7 pitch settings incl 0/1/4096/8191, %0d long stalls",
             empties, holds_done);
    if (fails == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
